// ===== hw/rtl/lmts_pkg.sv =====
// Shared types, constants and handshake structs for the LCD mode timing sequencer.
package lmts_pkg;

    localparam int TABLE_ENTRIES = 40;
    localparam int MAX_PER_LINE  = 10;
    localparam int TABLE_BYTES   = TABLE_ENTRIES * 4;
    localparam int ROW_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HIT_W         = $clog2(MAX_PER_LINE + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_ENABLE = 2'd0,
        CFG_TALL_SPRITES   = 2'd1,
        CFG_COMPARE_LINE   = 2'd2,
        CFG_STAT_ENABLES   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_HBLANK = 2'd0,
        ST_VBLANK = 2'd1,
        ST_SCAN   = 2'd2,
        ST_DRAW   = 2'd3
    } ppu_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_SCAN_RD,
        C_SCAN_CHK,
        C_STATUS
    } ctrl_state_t;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SPRITE = 1'b1;

    // stat_enables bit positions
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_SCAN   = 2;
    localparam int EN_COIN   = 3;

    localparam logic [12:0] SCAN_DOTS    = 13'd80;
    localparam logic [12:0] DRAW_DOTS    = 13'd172;
    localparam logic [12:0] HBLANK_DOTS  = 13'd204;
    localparam logic [12:0] VBLANK_DOTS  = 13'd4560;
    localparam logic [12:0] DOT_MAX      = 13'h1FFF;
    localparam logic [9:0]  LINE_DOTS    = 10'd456;
    localparam logic [9:0]  LINE_T_MAX   = 10'h3FF;
    localparam logic [7:0]  LAST_VIS_M1  = 8'd143;
    localparam logic [8:0]  SPRITE_OFS   = 9'd16;
    localparam logic [8:0]  HEIGHT_SHORT = 9'd8;
    localparam logic [8:0]  HEIGHT_TALL  = 9'd16;

    typedef struct packed {
        logic             tbl_write;
        logic             tick_take;
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             sprite_load;
        logic             status_load;
    } lmts_cmd_t;

    typedef struct packed {
        logic scan_pending;
        logic hit;
        logic out_free;
    } lmts_status_t;

endpackage

// ===== hw/rtl/lcd_mode_timing_sequencer_core.sv =====
// Top level of the LCD mode timing sequencer: controller, datapath and checks.
//
// Input channel (in_valid/in_ready) takes either a time tick (mode 0, cycles)
// or a sprite table byte write (mode 1, table_index, table_byte). Output
// channel (out_valid/out_ready) returns result transfers: zero or more sprite
// results followed by one status result with last set.
// A table write completes in the transfer cycle and gives no result.
// An ordinary tick is taken in C_IDLE and its status result is loaded in
// C_STATUS once the result register is free. The first tick of a line's
// sprite scan walks the table one entry per cycle from the byte-lane RAMs
// unless a hit waits for space, stopping early after MAX_PER_LINE hits.
// in_ready is low while a tick is in progress; one item is handled at a time.
// A full result register pauses the walk until out_ready takes the transfer.
// Reset clears timers, mode state, configuration and the per-byte valid bits
// of the sprite table, so the table reads as zero at once with no clearing
// pass. Configuration writes (cfg_we, cfg_index, cfg_data) apply next cycle;
// the user must make them only while the block is idle; nothing enforces it.
module lcd_mode_timing_sequencer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lmts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [7:0]                       cycles,
    input  logic [7:0]                       table_index,
    input  logic [7:0]                       table_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [1:0]                       ppu_state,
    output logic [7:0]                       line,
    output logic                             coincidence,
    output logic                             stat_irq,
    output logic [7:0]                       sprite_y,
    output logic [7:0]                       sprite_x,
    output logic [7:0]                       sprite_tile,
    output logic [7:0]                       sprite_flags,
    output logic                             last
);

    import lmts_pkg::*;

    lmts_cmd_t    cmd;
    lmts_status_t status;

    lmts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lmts_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cycles       (cycles),
        .table_index  (table_index),
        .table_byte   (table_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .ppu_state    (ppu_state),
        .line         (line),
        .coincidence  (coincidence),
        .stat_irq     (stat_irq),
        .sprite_y     (sprite_y),
        .sprite_x     (sprite_x),
        .sprite_tile  (sprite_tile),
        .sprite_flags (sprite_flags),
        .last         (last)
    );

    // no result is loaded while a new item may be taken
    a_no_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.sprite_load || cmd.status_load))
        else $error("result loaded while accepting input");

    // a waiting result is never overwritten
    a_load_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sprite_load || cmd.status_load) |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // a status result always closes a tick's transfers
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.status_load |=> (out_valid && last && (kind == KIND_STATUS)))
        else $error("status result malformed");

    // sprite results never carry the last mark
    a_sprite_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sprite_load |=> (out_valid && !last && (kind == KIND_SPRITE)))
        else $error("sprite result malformed");

endmodule

// ===== hw/rtl/lmts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lmts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 40,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/lmts_ctrl.sv =====
// Sequencer controller: item intake, sprite table walk and result ordering.
module lmts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_mode,
    output logic                  in_ready,
    input  lmts_pkg::lmts_status_t status,
    output lmts_pkg::lmts_cmd_t    cmd
);

    import lmts_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    logic [HIT_W-1:0] hits_reg, hits_next;
    logic             advance;
    logic             scan_done;

    assign advance   = !(status.hit && !status.out_free);
    assign scan_done = (cnt_reg == ROW_W'(TABLE_ENTRIES - 1))
                    || (status.hit && (hits_reg == HIT_W'(MAX_PER_LINE - 1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            hits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hits_reg  <= hits_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hits_next  = hits_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid && (in_mode == MODE_TICK))
                begin
                    state_next = status.scan_pending ? C_SCAN_RD : C_STATUS;
                end
            end
            C_SCAN_RD:
            begin
                cnt_next   = '0;
                hits_next  = '0;
                state_next = C_SCAN_CHK;
            end
            C_SCAN_CHK:
            begin
                if (advance)
                begin
                    if (status.hit)
                    begin
                        hits_next = hits_reg + HIT_W'(1);
                    end
                    if (scan_done)
                    begin
                        state_next = C_STATUS;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + ROW_W'(1);
                    end
                end
            end
            C_STATUS:
            begin
                if (status.out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.tbl_write = in_valid && (in_mode == MODE_WRITE);
                cmd.tick_take = in_valid && (in_mode == MODE_TICK);
            end
            C_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = '0;
            end
            C_SCAN_CHK:
            begin
                cmd.sprite_load = status.hit && status.out_free;
                cmd.rd_en       = advance && !scan_done;
                cmd.rd_row      = cnt_reg + ROW_W'(1);
            end
            C_STATUS:
            begin
                cmd.status_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lmts_datapath.sv =====
// Datapath: config registers, mode timers, sprite table, hit test and result register.
module lmts_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lmts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]                       cycles,
    input  logic [7:0]                       table_index,
    input  logic [7:0]                       table_byte,
    input  lmts_pkg::lmts_cmd_t              cmd,
    output lmts_pkg::lmts_status_t           status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [1:0]                       ppu_state,
    output logic [7:0]                       line,
    output logic                             coincidence,
    output logic                             stat_irq,
    output logic [7:0]                       sprite_y,
    output logic [7:0]                       sprite_x,
    output logic [7:0]                       sprite_tile,
    output logic [7:0]                       sprite_flags,
    output logic                             last
);

    import lmts_pkg::*;

    // configuration
    logic       display_en_reg;
    logic       tall_reg;
    logic [7:0] cmp_reg;
    logic [3:0] en_reg;

    // sequencer state
    logic [12:0] dot_reg, dot_next;
    logic [9:0]  line_t_reg, line_t_next;
    ppu_state_t  pstate_reg, pstate_next;
    logic        entered_reg, entered_next;
    logic        block_reg, block_next;
    logic [7:0]  line_reg, line_next;
    logic [7:0]  cyc_reg;
    logic        coin_next, pulse_next;

    // sprite table
    logic                     idx_ok;
    logic [ROW_W-1:0]         wr_row;
    logic [TABLE_ENTRIES-1:0] valid_reg [4];
    logic                     rd_valid_reg [4];
    logic [7:0]               ram_q [4];
    logic [7:0]               ent [4];
    logic [8:0]               pos, ytop, ybot, height;

    // result register
    logic       out_valid_reg;
    logic       kind_reg, coin_reg, irq_reg, last_reg;
    logic [1:0] pstate_out_reg;
    logic [7:0] line_out_reg, spy_reg, spx_reg, spt_reg, spf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_en_reg <= 1'b0;
            tall_reg       <= 1'b0;
            cmp_reg        <= '0;
            en_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE: display_en_reg <= cfg_data[0];
                CFG_TALL_SPRITES:   tall_reg       <= cfg_data[0];
                CFG_COMPARE_LINE:   cmp_reg        <= cfg_data;
                CFG_STAT_ENABLES:   en_reg         <= cfg_data[3:0];
                default:            en_reg         <= en_reg;
            endcase
        end
    end

    // table storage: one lane per byte of an entry
    assign idx_ok = ({1'b0, table_index} < 9'(TABLE_BYTES));
    assign wr_row = table_index[ROW_W+1:2];

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        lmts_ram #(
            .WIDTH(8),
            .DEPTH(TABLE_ENTRIES)
        ) u_ram (
            .clk     (clk),
            .wr_en   (cmd.tbl_write && idx_ok && (table_index[1:0] == 2'(g))),
            .wr_addr (wr_row),
            .wr_data (table_byte),
            .rd_en   (cmd.rd_en),
            .rd_addr (cmd.rd_row),
            .rd_data (ram_q[g])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g]    <= '0;
                rd_valid_reg[g] <= 1'b0;
            end
            else
            begin
                if (cmd.tbl_write && idx_ok && (table_index[1:0] == 2'(g)))
                begin
                    valid_reg[g][wr_row] <= 1'b1;
                end
                if (cmd.rd_en)
                begin
                    rd_valid_reg[g] <= valid_reg[g][cmd.rd_row];
                end
            end
        end

        assign ent[g] = rd_valid_reg[g] ? ram_q[g] : 8'h00;
    end

    assign height = tall_reg ? HEIGHT_TALL : HEIGHT_SHORT;
    assign pos    = {1'b0, line_reg} + SPRITE_OFS;
    assign ytop   = {1'b0, ent[0]};
    assign ybot   = ytop + height;

    assign status.hit          = (ent[1] != 8'h00) && (pos >= ytop) && (pos < ybot);
    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.scan_pending = display_en_reg && (pstate_reg == ST_SCAN) && !entered_reg;

    // one tick of the mode sequencer
    always_comb
    begin
        logic [13:0] dot_sum;
        logic [10:0] lt_sum;
        logic [12:0] dot_sat;
        logic        do_enter;
        ppu_state_t  enter_st;
        logic        entry_en;

        dot_sum      = {1'b0, dot_reg} + 14'(cyc_reg);
        dot_sat      = dot_sum[13] ? DOT_MAX : dot_sum[12:0];
        lt_sum       = {1'b0, line_t_reg} + 11'(cyc_reg);
        do_enter     = 1'b0;
        enter_st     = ST_SCAN;
        entry_en     = 1'b0;
        dot_next     = dot_sat;
        line_t_next  = line_t_reg;
        pstate_next  = pstate_reg;
        entered_next = entered_reg;
        block_next   = block_reg;
        line_next    = line_reg;
        pulse_next   = 1'b0;
        coin_next    = 1'b0;

        if (!display_en_reg)
        begin
            dot_next     = '0;
            line_t_next  = '0;
            pstate_next  = ST_SCAN;
            entered_next = 1'b0;
            coin_next    = (line_reg == cmp_reg);
        end
        else
        begin
            unique case (pstate_reg)
                ST_SCAN:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                    end
                    else if (dot_sat >= SCAN_DOTS)
                    begin
                        do_enter = 1'b1;
                        enter_st = ST_DRAW;
                    end
                end
                ST_DRAW:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                    end
                    else if (dot_sat >= DRAW_DOTS)
                    begin
                        do_enter = 1'b1;
                        enter_st = ST_HBLANK;
                    end
                end
                ST_HBLANK:
                begin
                    if (!entered_reg)
                    begin
                        entered_next = 1'b1;
                    end
                    else if (dot_sat >= HBLANK_DOTS)
                    begin
                        do_enter  = 1'b1;
                        enter_st  = (line_reg < LAST_VIS_M1) ? ST_SCAN : ST_VBLANK;
                        line_next = line_reg + 8'd1;
                    end
                end
                ST_VBLANK:
                begin
                    line_t_next = lt_sum[10] ? LINE_T_MAX : lt_sum[9:0];
                    if (dot_sat >= VBLANK_DOTS)
                    begin
                        do_enter    = 1'b1;
                        enter_st    = ST_SCAN;
                        line_next   = '0;
                        line_t_next = '0;
                    end
                    else if (line_t_next >= LINE_DOTS)
                    begin
                        line_next   = line_reg + 8'd1;
                        line_t_next = '0;
                    end
                end
                default:
                begin
                    entered_next = entered_reg;
                end
            endcase

            unique case (enter_st)
                ST_HBLANK: entry_en = en_reg[EN_HBLANK];
                ST_VBLANK: entry_en = en_reg[EN_VBLANK];
                ST_SCAN:   entry_en = en_reg[EN_SCAN];
                default:   entry_en = 1'b0;
            endcase

            if (do_enter)
            begin
                entered_next = 1'b0;
                pstate_next  = enter_st;
                dot_next     = '0;
                if (entry_en)
                begin
                    if (!block_reg)
                    begin
                        block_next = 1'b1;
                        pulse_next = 1'b1;
                    end
                end
                else if (enter_st != ST_DRAW)
                begin
                    block_next = 1'b0;
                end
            end

            if (line_next == cmp_reg)
            begin
                coin_next = 1'b1;
                if (en_reg[EN_COIN] && !block_next)
                begin
                    block_next = 1'b1;
                    pulse_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg     <= '0;
            line_t_reg  <= '0;
            pstate_reg  <= ST_SCAN;
            entered_reg <= 1'b0;
            block_reg   <= 1'b0;
            line_reg    <= '0;
        end
        else if (cmd.status_load)
        begin
            dot_reg     <= dot_next;
            line_t_reg  <= line_t_next;
            pstate_reg  <= pstate_next;
            entered_reg <= entered_next;
            block_reg   <= block_next;
            line_reg    <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_take)
        begin
            cyc_reg <= cycles;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.sprite_load || cmd.status_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sprite_load)
        begin
            kind_reg       <= KIND_SPRITE;
            pstate_out_reg <= '0;
            line_out_reg   <= '0;
            coin_reg       <= 1'b0;
            irq_reg        <= 1'b0;
            spy_reg        <= ent[0];
            spx_reg        <= ent[1];
            spt_reg        <= ent[2];
            spf_reg        <= ent[3];
            last_reg       <= 1'b0;
        end
        else if (cmd.status_load)
        begin
            kind_reg       <= KIND_STATUS;
            pstate_out_reg <= pstate_next;
            line_out_reg   <= line_next;
            coin_reg       <= coin_next;
            irq_reg        <= pulse_next;
            spy_reg        <= '0;
            spx_reg        <= '0;
            spt_reg        <= '0;
            spf_reg        <= '0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign ppu_state    = pstate_out_reg;
    assign line         = line_out_reg;
    assign coincidence  = coin_reg;
    assign stat_irq     = irq_reg;
    assign sprite_y     = spy_reg;
    assign sprite_x     = spx_reg;
    assign sprite_tile  = spt_reg;
    assign sprite_flags = spf_reg;
    assign last         = last_reg;

endmodule
